[rtl/assert_macros.svh]
// assertion macros shared by the checker files
// no dependencies; clocked on clk_i with active-low reset rst_ni
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked at every edge, reset included
`define ASSERT_CLK_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

[rtl/i8gemv_pkg.sv]
// shared types and constants for the int8 matrix-vector requantize block
// no dependencies
package i8gemv_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 4;
  localparam int unsigned ACC_W   = 32;
  localparam int unsigned ELEM_W  = 8;
  localparam int unsigned OFS_W   = 9;
  localparam int unsigned OUT_W   = 8;
  localparam int unsigned MULT_W  = 32;
  localparam int unsigned SHIFT_W = 6;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned RSHIFT_MAX = 30;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_VECTOR_OFFSET    = 3'd0,
    REG_MATRIX_OFFSET    = 3'd1,
    REG_OUTPUT_OFFSET    = 3'd2,
    REG_QUANT_MULTIPLIER = 3'd3,
    REG_QUANT_SHIFT      = 3'd4,
    REG_CLAMP_LOW        = 3'd5,
    REG_CLAMP_HIGH       = 3'd6
  } reg_idx_e;

  // settings seen by the multiply-accumulate front
  typedef struct packed {
    logic [OFS_W-1:0] vector_offset;
    logic [OFS_W-1:0] matrix_offset;
  } mac_cfg_t;

  // settings seen by the requantize back end
  typedef struct packed {
    logic [OUT_W-1:0]   output_offset;
    logic [MULT_W-1:0]  quant_multiplier;
    logic [SHIFT_W-1:0] quant_shift;
    logic [OUT_W-1:0]   clamp_low;
    logic [OUT_W-1:0]   clamp_high;
  } rq_cfg_t;

  // queue status toward both sides
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

[rtl/i8gemv_fifo.sv]
// short queue of row accumulators between the front and the back end
// depends on i8gemv_pkg
module i8gemv_fifo import i8gemv_pkg::*; #(
  parameter int unsigned Depth = QUEUE_DEPTH_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [ACC_W-1:0] push_data_i,
  input  logic             pop_i,
  output logic [ACC_W-1:0] pop_data_o,
  output q_stat_t          stat_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [ACC_W-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    case ({push_i, pop_i})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign pop_data_o   = mem_q[rd_ptr_q];
  assign stat_o.full  = (count_q == CntW'(Depth));
  assign stat_o.empty = (count_q == '0);

endmodule

[rtl/i8gemv_front.sv]
// input side: offsets, multiplies and accumulates one element per transfer
// depends on i8gemv_pkg; feeds finished rows into i8gemv_fifo
module i8gemv_front import i8gemv_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mac_cfg_t          cfg_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [ELEM_W-1:0] vector_element_i,
  input  logic [ELEM_W-1:0] matrix_element_i,
  input  logic [ACC_W-1:0]  row_bias_i,
  input  logic              first_of_row_i,
  input  logic              last_of_row_i,
  input  q_stat_t           q_stat_i,
  output logic              push_o,
  output logic [ACC_W-1:0]  push_data_o
);

  localparam int unsigned OpW   = OFS_W + 1;
  localparam int unsigned ProdW = 2 * OpW;

  logic              accept;
  logic signed [OpW-1:0]   v_op, m_op;
  logic signed [ProdW-1:0] prod;
  logic [ACC_W-1:0]  base;
  logic [ACC_W-1:0]  acc_q, acc_d;

  assign in_ready_o = !q_stat_i.full;
  assign accept     = in_valid_i && in_ready_o;

  // offset operands and product
  assign v_op = {{(OpW - ELEM_W){vector_element_i[ELEM_W-1]}}, vector_element_i}
              + {cfg_i.vector_offset[OFS_W-1], cfg_i.vector_offset};
  assign m_op = {{(OpW - ELEM_W){matrix_element_i[ELEM_W-1]}}, matrix_element_i}
              + {cfg_i.matrix_offset[OFS_W-1], cfg_i.matrix_offset};
  assign prod = v_op * m_op;

  // accumulate, restarting from the bias on the first column
  assign base  = first_of_row_i ? row_bias_i : acc_q;
  assign acc_d = base + {{(ACC_W - ProdW){prod[ProdW-1]}}, prod};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else if (accept) begin
      acc_q <= acc_d;
    end
  end

  // last column hands the row total to the queue
  assign push_o      = accept && last_of_row_i;
  assign push_data_o = acc_d;

endmodule

[rtl/i8gemv_back.sv]
// requantize pipeline: shift, q31 multiply, rounding shift, offset and clamp
// depends on i8gemv_pkg; drains i8gemv_fifo
module i8gemv_back import i8gemv_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  rq_cfg_t          cfg_i,
  input  q_stat_t          q_stat_i,
  output logic             pop_o,
  input  logic [ACC_W-1:0] pop_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [OUT_W-1:0] result_value_o
);

  localparam int unsigned ProdW = ACC_W + MULT_W;
  localparam int unsigned EW    = $clog2(RSHIFT_MAX + 1);
  localparam logic signed [ProdW-1:0] RoundHalf = ProdW'(64'h4000_0000);

  logic adv;

  // stage valids and payloads
  logic                    s1_vld_q, s2_vld_q, s3_vld_q, s4_vld_q, out_vld_q;
  logic signed [ACC_W-1:0] s1_x_q, s3_y_q, s4_r_q;
  logic signed [ProdW-1:0] s2_prod_q;
  logic [OUT_W-1:0]        out_q;

  logic [SHIFT_W-2:0]      left;
  logic signed [ProdW-1:0] prod, prod_rnd;
  logic [SHIFT_W-1:0]      neg_shift;
  logic [EW-1:0]           e;
  logic [ACC_W-1:0]        mask, rem, thr;
  logic signed [ACC_W-1:0] res, r_d;
  logic signed [ACC_W-1:0] z, lo, hi, z_lo, z_cl;

  // whole pipeline moves unless the output is held
  assign adv   = !out_vld_q || out_ready_i;
  assign pop_o = adv && !q_stat_i.empty;

  // left shift for positive shift settings
  assign left = cfg_i.quant_shift[SHIFT_W-1] ? '0 : cfg_i.quant_shift[SHIFT_W-2:0];

  // q31 product
  assign prod = s1_x_q * $signed(cfg_i.quant_multiplier);

  // add half and keep bits 62..31
  assign prod_rnd = s2_prod_q + RoundHalf;

  // rounding right shift, half away from zero, limited to 30
  assign neg_shift = SHIFT_W'(-$signed(cfg_i.quant_shift));
  assign e    = (neg_shift > SHIFT_W'(RSHIFT_MAX)) ? EW'(RSHIFT_MAX) : neg_shift[EW-1:0];
  assign mask = (ACC_W'(1) << e) - 1'b1;
  assign rem  = s3_y_q & mask;
  assign res  = s3_y_q >>> e;
  assign thr  = (mask >> 1) + ACC_W'(s3_y_q[ACC_W-1]);
  assign r_d  = cfg_i.quant_shift[SHIFT_W-1] ? res + ACC_W'(rem > thr) : s3_y_q;

  // output offset and activation clamp
  assign z    = s4_r_q + {{(ACC_W - OUT_W){cfg_i.output_offset[OUT_W-1]}}, cfg_i.output_offset};
  assign lo   = {{(ACC_W - OUT_W){cfg_i.clamp_low[OUT_W-1]}}, cfg_i.clamp_low};
  assign hi   = {{(ACC_W - OUT_W){cfg_i.clamp_high[OUT_W-1]}}, cfg_i.clamp_high};
  assign z_lo = (z > lo) ? z : lo;
  assign z_cl = (z_lo < hi) ? z_lo : hi;

  // stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      s3_vld_q  <= 1'b0;
      s4_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      s1_vld_q  <= pop_o;
      s2_vld_q  <= s1_vld_q;
      s3_vld_q  <= s2_vld_q;
      s4_vld_q  <= s3_vld_q;
      out_vld_q <= s4_vld_q;
    end
  end

  // stage payloads
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_x_q    <= pop_data_i << left;
      s2_prod_q <= prod;
      s3_y_q    <= prod_rnd[ProdW-2:ProdW-1-ACC_W];
      s4_r_q    <= r_d;
      out_q     <= z_cl[OUT_W-1:0];
    end
  end

  assign out_valid_o    = out_vld_q;
  assign result_value_o = out_q;

endmodule

[rtl/int8_gemv_requantize.sv]
// top level of the int8 matrix-vector multiply with requantization
// depends on i8gemv_pkg, i8gemv_front, i8gemv_fifo and i8gemv_back
//
// One column element is taken per transfer, up to one transfer every clock cycle:
// the front offsets both elements, multiplies them and adds the product to the
// 32-bit row accumulator in the cycle of the transfer, with first_of_row loading
// the bias. A transfer marked last_of_row places the row total in a queue of
// QueueDepth entries; the requantize pipeline drains it, one row per cycle while
// the output side does not stall. Input ready drops only while that queue is
// full. Configuration is written through cfg_we_i, cfg_index_i and cfg_wdata_i;
// the user must write it only while no row is in flight, and the block does not
// enforce this. Indexes past the last register are ignored.
module int8_gemv_requantize import i8gemv_pkg::*; #(
  parameter int unsigned QueueDepth = QUEUE_DEPTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [MULT_W-1:0]    cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [ELEM_W-1:0]    vector_element_i,
  input  logic [ELEM_W-1:0]    matrix_element_i,
  input  logic [ACC_W-1:0]     row_bias_i,
  input  logic                 first_of_row_i,
  input  logic                 last_of_row_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [OUT_W-1:0]     result_value_o
);

  logic [OFS_W-1:0]   vector_offset_q, matrix_offset_q;
  logic [OUT_W-1:0]   output_offset_q, clamp_low_q, clamp_high_q;
  logic [MULT_W-1:0]  quant_multiplier_q;
  logic [SHIFT_W-1:0] quant_shift_q;

  mac_cfg_t         mac_cfg;
  rq_cfg_t          rq_cfg;
  q_stat_t          q_stat;
  logic             push, pop;
  logic [ACC_W-1:0] push_data, pop_data;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vector_offset_q    <= '0;
      matrix_offset_q    <= '0;
      output_offset_q    <= '0;
      quant_multiplier_q <= MULT_W'(32'h4000_0000);
      quant_shift_q      <= '0;
      clamp_low_q        <= OUT_W'(8'h80);
      clamp_high_q       <= OUT_W'(8'h7F);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_VECTOR_OFFSET:    vector_offset_q    <= cfg_wdata_i[OFS_W-1:0];
        REG_MATRIX_OFFSET:    matrix_offset_q    <= cfg_wdata_i[OFS_W-1:0];
        REG_OUTPUT_OFFSET:    output_offset_q    <= cfg_wdata_i[OUT_W-1:0];
        REG_QUANT_MULTIPLIER: quant_multiplier_q <= cfg_wdata_i;
        REG_QUANT_SHIFT:      quant_shift_q      <= cfg_wdata_i[SHIFT_W-1:0];
        REG_CLAMP_LOW:        clamp_low_q        <= cfg_wdata_i[OUT_W-1:0];
        REG_CLAMP_HIGH:       clamp_high_q       <= cfg_wdata_i[OUT_W-1:0];
        default: ;
      endcase
    end
  end

  assign mac_cfg.vector_offset    = vector_offset_q;
  assign mac_cfg.matrix_offset    = matrix_offset_q;
  assign rq_cfg.output_offset     = output_offset_q;
  assign rq_cfg.quant_multiplier  = quant_multiplier_q;
  assign rq_cfg.quant_shift       = quant_shift_q;
  assign rq_cfg.clamp_low         = clamp_low_q;
  assign rq_cfg.clamp_high        = clamp_high_q;

  // accumulate side
  i8gemv_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (mac_cfg),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .vector_element_i (vector_element_i),
    .matrix_element_i (matrix_element_i),
    .row_bias_i       (row_bias_i),
    .first_of_row_i   (first_of_row_i),
    .last_of_row_i    (last_of_row_i),
    .q_stat_i         (q_stat),
    .push_o           (push),
    .push_data_o      (push_data)
  );

  // row queue
  i8gemv_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .stat_o      (q_stat)
  );

  // requantize side
  i8gemv_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (rq_cfg),
    .q_stat_i       (q_stat),
    .pop_o          (pop),
    .pop_data_i     (pop_data),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .result_value_o (result_value_o)
  );

endmodule

[rtl/i8gemv_checker.sv]
// port-level checks for int8_gemv_requantize, attached by bind
// depends on assert_macros.svh and i8gemv_pkg
`include "assert_macros.svh"

module i8gemv_checker import i8gemv_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_o,
  input logic             last_of_row_i,
  input logic             out_valid_o,
  input logic             out_ready_i,
  input logic [OUT_W-1:0] result_value_o
);

  logic       row_in, row_out;
  logic [7:0] pend_q;

  assign row_in  = in_valid_i && in_ready_o && last_of_row_i;
  assign row_out = out_valid_o && out_ready_i;

  // rows taken in but not yet delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      case ({row_in, row_out})
        2'b10:   pend_q <= pend_q + 1'b1;
        2'b01:   pend_q <= pend_q - 1'b1;
        default: pend_q <= pend_q;
      endcase
    end
  end

  `ASSERT_CLK_ALWAYS(a_no_out_in_reset, !rst_ni |=> !out_valid_o, "result shown in reset")
  `ASSERT_CLK(a_out_has_row, out_valid_o |-> pend_q != 8'd0, "result without a finished row")
  `ASSERT_CLK(a_idle_ready, pend_q == 8'd0 |-> in_ready_o, "input stalled with no row in flight")
  `ASSERT_CLK(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(result_value_o), "stalled result changed")

endmodule

bind int8_gemv_requantize i8gemv_checker u_checker (.*);

[verif/gemv_row_checker.sv]
// checker for the int8 matrix-vector requantize block: mirrors the config port,
// predicts one int8 result per finished row and compares it against the output channel
// depends on i8gemv_pkg
module gemv_row_checker import i8gemv_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [MULT_W-1:0]    cfg_wdata_i,
  input  logic                 in_valid_i,
  input  logic                 in_ready_i,
  input  logic [ELEM_W-1:0]    vector_element_i,
  input  logic [ELEM_W-1:0]    matrix_element_i,
  input  logic [ACC_W-1:0]     row_bias_i,
  input  logic                 first_of_row_i,
  input  logic                 last_of_row_i,
  input  logic                 out_valid_i,
  input  logic                 out_ready_i,
  input  logic [OUT_W-1:0]     result_value_i,
  output int                   mismatch_count_o,
  output int                   rows_pending_o
);

  localparam int PRINT_LIMIT = 100;

  // mirrored settings
  logic signed [OFS_W-1:0]   vec_ofs;
  logic signed [OFS_W-1:0]   mat_ofs;
  logic signed [OUT_W-1:0]   out_ofs;
  logic signed [MULT_W-1:0]  q_mult;
  logic signed [SHIFT_W-1:0] q_shift;
  logic signed [OUT_W-1:0]   clamp_lo;
  logic signed [OUT_W-1:0]   clamp_hi;

  // running row total and results still owed by the block
  logic [ACC_W-1:0] row_total;
  logic [OUT_W-1:0] owed_results[$];
  int               mismatches = 0;
  int               rows_done = 0;

  task automatic report_mismatch(input string msg);
    if (mismatches < PRINT_LIMIT) $display("%0t gemv check: %s", $time, msg);
    mismatches++;
  endtask

  // scale a row total down to the clamped int8 result
  function automatic logic [OUT_W-1:0] requantize_row(input logic [ACC_W-1:0] total);
    int               left;
    int               right;
    int               e;
    logic [ACC_W-1:0] shifted;
    longint           prod;
    longint           y;
    longint           res;
    longint           mask;
    longint           rem;
    longint           thr;
    longint           z;
    longint           lo;
    longint           hi;
    left    = (q_shift > 0) ? int'(q_shift) : 0;
    right   = (q_shift < 0) ? -int'(q_shift) : 0;
    shifted = total << left;
    prod    = longint'(signed'(shifted)) * longint'(q_mult) + (longint'(1) << 30);
    y       = prod >>> 31;
    y       = longint'(signed'(y[31:0]));
    // rounding right shift, half away from zero, capped at 30
    if (right > 0) begin
      e    = (right > int'(RSHIFT_MAX)) ? int'(RSHIFT_MAX) : right;
      mask = (longint'(1) << e) - 1;
      rem  = y & mask;
      res  = y >>> e;
      thr  = mask >>> 1;
      if (res < 0) thr = thr + 1;
      if (rem > thr) res = res + 1;
      y = res;
    end
    z  = y + longint'(out_ofs);
    z  = longint'(signed'(z[31:0]));
    lo = longint'(clamp_lo);
    hi = longint'(clamp_hi);
    if (!(z > lo)) z = lo;
    if (!(z < hi)) z = hi;
    return z[OUT_W-1:0];
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : track
    longint           product;
    logic [ACC_W-1:0] base;
    logic [OUT_W-1:0] want;
    if (!rst_ni) begin
      vec_ofs   = '0;
      mat_ofs   = '0;
      out_ofs   = '0;
      q_mult    = 32'h4000_0000;
      q_shift   = '0;
      clamp_lo  = 8'h80;
      clamp_hi  = 8'h7F;
      row_total = '0;
      owed_results.delete();
    end else begin
      // register writes, unused indexes fall through
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_VECTOR_OFFSET:    vec_ofs  = cfg_wdata_i[OFS_W-1:0];
          REG_MATRIX_OFFSET:    mat_ofs  = cfg_wdata_i[OFS_W-1:0];
          REG_OUTPUT_OFFSET:    out_ofs  = cfg_wdata_i[OUT_W-1:0];
          REG_QUANT_MULTIPLIER: q_mult   = cfg_wdata_i;
          REG_QUANT_SHIFT:      q_shift  = cfg_wdata_i[SHIFT_W-1:0];
          REG_CLAMP_LOW:        clamp_lo = cfg_wdata_i[OUT_W-1:0];
          REG_CLAMP_HIGH:       clamp_hi = cfg_wdata_i[OUT_W-1:0];
          default: ;
        endcase
      end

      // output transfer against the oldest owed result
      if (out_valid_i && out_ready_i) begin
        if (owed_results.size() == 0) begin
          report_mismatch($sformatf("result %0d with no row pending",
                                    $signed(result_value_i)));
        end else begin
          want = owed_results.pop_front();
          if (result_value_i !== want)
            report_mismatch($sformatf("row %0d: result %0d, predicted %0d", rows_done,
                                      $signed(result_value_i), $signed(want)));
          rows_done++;
        end
      end

      // input transfer: multiply-accumulate, close the row on the last mark
      if (in_valid_i && in_ready_i) begin
        product = (longint'(signed'(vector_element_i)) + longint'(vec_ofs)) *
                  (longint'(signed'(matrix_element_i)) + longint'(mat_ofs));
        base      = first_of_row_i ? row_bias_i : row_total;
        row_total = base + product[ACC_W-1:0];
        // append at the tail of the owed list
        if (last_of_row_i)
          owed_results.insert(owed_results.size(), requantize_row(row_total));
      end
    end
    mismatch_count_o <= mismatches;
    rows_pending_o   <= owed_results.size();
  end

endmodule

[verif/tb_top.sv]
// top of the int8 matrix-vector requantize testbench: clock, reset, config
// writes, row stimulus with random gaps and output stalls, watchdog and verdict
// depends on i8gemv_pkg, int8_gemv_requantize and gemv_row_checker
module tb_top;
  import i8gemv_pkg::*;

  localparam int RANDOM_PHASES   = 12;
  localparam int ITEMS_PER_PHASE = 112;
  localparam int SETTLE_CYCLES   = 12;
  localparam int QUIET_LIMIT     = 2000;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  logic                 clk_i            = 1'b0;
  logic                 rst_ni           = 1'b0;
  logic                 cfg_we_i         = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i      = '0;
  logic [MULT_W-1:0]    cfg_wdata_i      = '0;
  logic                 in_valid_i       = 1'b0;
  logic [ELEM_W-1:0]    vector_element_i = '0;
  logic [ELEM_W-1:0]    matrix_element_i = '0;
  logic [ACC_W-1:0]     row_bias_i       = '0;
  logic                 first_of_row_i   = 1'b0;
  logic                 last_of_row_i    = 1'b0;
  logic                 out_ready_i      = 1'b0;
  logic                 in_ready_o;
  logic                 out_valid_o;
  logic [OUT_W-1:0]     result_value_o;

  int mismatch_count;
  int rows_pending;
  int quiet_cycles = 0;
  bit dense_row    = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  int8_gemv_requantize dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .vector_element_i (vector_element_i),
    .matrix_element_i (matrix_element_i),
    .row_bias_i       (row_bias_i),
    .first_of_row_i   (first_of_row_i),
    .last_of_row_i    (last_of_row_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .result_value_o   (result_value_o)
  );

  gemv_row_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_ready_i       (in_ready_o),
    .vector_element_i (vector_element_i),
    .matrix_element_i (matrix_element_i),
    .row_bias_i       (row_bias_i),
    .first_of_row_i   (first_of_row_i),
    .last_of_row_i    (last_of_row_i),
    .out_valid_i      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .result_value_i   (result_value_o),
    .mismatch_count_o (mismatch_count),
    .rows_pending_o   (rows_pending)
  );

  // mostly no gap, some short ones, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [ELEM_W-1:0] pick_element();
    case ($urandom_range(0, 9))
      0:       return 8'h80;
      1:       return 8'h7F;
      default: return ELEM_W'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [ACC_W-1:0] pick_bias();
    case ($urandom_range(0, 15))
      0, 1, 2, 3: return '0;
      4, 5, 6:    return ACC_W'($urandom_range(0, 65535) - 32768);
      7:          return 32'h7FFF_FFFF;
      8:          return 32'h8000_0000;
      default:    return $urandom();
    endcase
  endfunction

  // offsets may leave the nominal range, the register takes the bits as given
  function automatic logic [OFS_W-1:0] pick_offset();
    case ($urandom_range(0, 9))
      0:       return 9'h180;
      1:       return 9'h080;
      2:       return OFS_W'($urandom_range(0, 511));
      default: return OFS_W'($urandom_range(0, 256) - 128);
    endcase
  endfunction

  function automatic logic [MULT_W-1:0] pick_multiplier();
    case ($urandom_range(0, 9))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return '0;
      3:       return $urandom();
      default: return $urandom_range(32'h7FFF_FFFF, 32'h4000_0000);
    endcase
  endfunction

  // mostly right shifts that bring row totals near the int8 range
  function automatic logic [SHIFT_W-1:0] pick_shift();
    case ($urandom_range(0, 9))
      0:       return 6'h1F;
      1:       return 6'h20;
      2:       return '0;
      3:       return SHIFT_W'($urandom_range(0, 63));
      default: return SHIFT_W'(64 - $urandom_range(4, 16));
    endcase
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [MULT_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // one column transfer, then an optional gap
  task automatic send_element(input logic [ELEM_W-1:0] v, input logic [ELEM_W-1:0] m,
                              input logic [ACC_W-1:0] bias, input logic first,
                              input logic last);
    int gap;
    in_valid_i       <= 1'b1;
    vector_element_i <= v;
    matrix_element_i <= m;
    row_bias_i       <= bias;
    first_of_row_i   <= first;
    last_of_row_i    <= last;
    do @(posedge clk_i); while (!in_ready_o);
    gap = dense_row ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // stop sending, let every owed result come out, then let the pipe settle
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (rows_pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // mostly well-formed rows, the rest with random marks
  task automatic send_random_row(output int sent);
    int               len;
    int               kind;
    logic [ACC_W-1:0] bias;
    kind      = $urandom_range(0, 99);
    len       = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 6);
    bias      = pick_bias();
    dense_row = ($urandom_range(0, 4) == 0);
    for (int i = 0; i < len; i++) begin
      if (kind < 85)
        send_element(pick_element(), pick_element(), bias, i == 0, i == len - 1);
      else
        send_element(pick_element(), pick_element(), $urandom(),
                     $urandom_range(0, 3) == 0, $urandom_range(0, 2) == 0);
    end
    sent = len;
  endtask

  task automatic program_random_setting();
    logic [MULT_W-1:0] data;
    logic [OUT_W-1:0]  lo;
    logic [OUT_W-1:0]  hi;
    logic [OUT_W-1:0]  swap;
    data = $urandom();
    data[OFS_W-1:0] = pick_offset();
    write_reg(REG_VECTOR_OFFSET, data);
    data = $urandom();
    data[OFS_W-1:0] = pick_offset();
    write_reg(REG_MATRIX_OFFSET, data);
    data = $urandom();
    if ($urandom_range(0, 4) == 0) data[OUT_W-1:0] = $urandom_range(0, 1) ? 8'h7F : 8'h80;
    write_reg(REG_OUTPUT_OFFSET, data);
    write_reg(REG_QUANT_MULTIPLIER, pick_multiplier());
    data = $urandom();
    data[SHIFT_W-1:0] = pick_shift();
    write_reg(REG_QUANT_SHIFT, data);
    // clamp limits: usually ordered, sometimes full range, sometimes crossed
    lo = OUT_W'($urandom_range(0, 255));
    hi = OUT_W'($urandom_range(0, 255));
    case ($urandom_range(0, 9))
      0: begin
        lo = 8'h80;
        hi = 8'h7F;
      end
      1: ;
      default: begin
        if ($signed(lo) > $signed(hi)) begin
          swap = lo;
          lo   = hi;
          hi   = swap;
        end
      end
    endcase
    data = $urandom();
    data[OUT_W-1:0] = lo;
    write_reg(REG_CLAMP_LOW, data);
    data = $urandom();
    data[OUT_W-1:0] = hi;
    write_reg(REG_CLAMP_HIGH, data);
    if ($urandom_range(0, 3) == 0) write_reg(REG_UNUSED, $urandom());
  endtask

  // output side: ready runs broken by random stalls, now and then a long clean run
  initial begin
    int run;
    int stall;
    @(posedge clk_i);
    forever begin
      run = ($urandom_range(0, 9) == 0) ? 60 : $urandom_range(1, 16);
      out_ready_i <= 1'b1;
      repeat (run) @(posedge clk_i);
      stall = pick_gap();
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("FAIL int8_gemv_requantize");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int  items;
    int  sent;
    bit  paused;
    paused = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: single-element rows at the element and bias extremes
    send_element(8'h7F, 8'h7F, 32'h7FFF_FFFF, 1'b1, 1'b1);
    send_element(8'h80, 8'h80, 32'h8000_0000, 1'b1, 1'b1);
    // three-column row, then a row without first mark that keeps the total
    send_element(8'h80, 8'h7F, 32'd12345, 1'b1, 1'b0);
    send_element(8'h05, 8'hF9, 32'hFFFF_FFFF, 1'b0, 1'b0);
    send_element(8'h00, 8'h00, 32'h0, 1'b0, 1'b1);
    send_element(8'h64, 8'h64, 32'hFFFF_FFFF, 1'b0, 1'b1);
    // column with neither mark, closed by the next one
    send_element(8'hFF, 8'hFF, 32'h5A5A_5A5A, 1'b0, 1'b0);
    send_element(8'h03, 8'h03, 32'h0, 1'b0, 1'b1);
    wait_drained();

    // unused index must change nothing; then top-end extremes with crossed clamps
    write_reg(REG_UNUSED, 32'hFFFF_FFFF);
    write_reg(REG_VECTOR_OFFSET, 32'h080);
    write_reg(REG_MATRIX_OFFSET, 32'h180);
    write_reg(REG_OUTPUT_OFFSET, 32'h7F);
    write_reg(REG_QUANT_MULTIPLIER, 32'h7FFF_FFFF);
    write_reg(REG_QUANT_SHIFT, 32'h1F);
    write_reg(REG_CLAMP_LOW, 32'h7F);
    write_reg(REG_CLAMP_HIGH, 32'h80);
    send_element(8'h7F, 8'h80, 32'h0, 1'b1, 1'b1);
    send_element(8'h80, 8'h7F, 32'h1, 1'b1, 1'b1);
    send_element(8'h01, 8'h01, 32'h4000_0000, 1'b1, 1'b1);
    wait_drained();

    // out-of-range offsets, most negative multiplier, right shift past the cap
    write_reg(REG_VECTOR_OFFSET, 32'h0FF);
    write_reg(REG_MATRIX_OFFSET, 32'h100);
    write_reg(REG_OUTPUT_OFFSET, 32'h80);
    write_reg(REG_QUANT_MULTIPLIER, 32'h8000_0000);
    write_reg(REG_QUANT_SHIFT, 32'h20);
    write_reg(REG_CLAMP_LOW, 32'h80);
    write_reg(REG_CLAMP_HIGH, 32'h7F);
    send_element(8'h7F, 8'h7F, 32'h0, 1'b1, 1'b1);
    send_element(8'h80, 8'h80, 32'h7FFF_FFFF, 1'b1, 1'b1);
    send_element(8'h01, 8'hFF, 32'h8000_0000, 1'b1, 1'b1);
    wait_drained();

    // half multiplier and a one-bit right shift: rounding of ties both signs
    write_reg(REG_VECTOR_OFFSET, 32'h0);
    write_reg(REG_MATRIX_OFFSET, 32'h0);
    write_reg(REG_OUTPUT_OFFSET, 32'h0);
    write_reg(REG_QUANT_MULTIPLIER, 32'h4000_0000);
    write_reg(REG_QUANT_SHIFT, 32'h3F);
    send_element(8'h00, 8'h00, 32'd3, 1'b1, 1'b1);
    send_element(8'h00, 8'h00, -32'sd3, 1'b1, 1'b1);
    send_element(8'h00, 8'h00, 32'd1, 1'b1, 1'b1);
    send_element(8'h00, 8'h00, -32'sd1, 1'b1, 1'b1);
    send_element(8'h00, 8'h00, 32'd6, 1'b1, 1'b1);
    send_element(8'h00, 8'h00, -32'sd6, 1'b1, 1'b1);
    wait_drained();

    // random phases, each under its own setting
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      program_random_setting();
      items = 0;
      while (items < ITEMS_PER_PHASE) begin
        send_random_row(sent);
        items += sent;
        // hold off the sender once mid-phase until the block is empty
        if (phase == RANDOM_PHASES / 2 && !paused && items >= ITEMS_PER_PHASE / 2) begin
          paused = 1'b1;
          wait_drained();
        end
      end
      wait_drained();
    end

    if (mismatch_count == 0 && rows_pending == 0) begin
      $display("PASS int8_gemv_requantize");
    end else begin
      $display("FAIL int8_gemv_requantize");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+rtl
rtl/i8gemv_pkg.sv
rtl/i8gemv_fifo.sv
rtl/i8gemv_front.sv
rtl/i8gemv_back.sv
rtl/int8_gemv_requantize.sv
rtl/i8gemv_checker.sv
verif/gemv_row_checker.sv
verif/tb_top.sv
